// ----- rtl/imh_pkg.sv -----
// ----------------------------------------------------------------------------
// imh_pkg
// Types and codes shared by the indexed min-heap block.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int ID_W  = 10;
  localparam int KEY_W = 32;

  // Request codes; 6 and 7 decode as read min.
  typedef enum logic [2:0] {
    OP_SET_KEY  = 3'd0,
    OP_UPDATE   = 3'd1,
    OP_INSERT   = 3'd2,
    OP_REMOVE   = 3'd3,
    OP_READ_MIN = 3'd4,
    OP_REBUILD  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_MEMBERSHIP = 2'd1,
    STS_BAD_ID     = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_INS_RD,
    S_INS_SWP,
    S_INS_DONE,
    S_REM_RD,
    S_REM_SWP,
    S_REM_DONE,
    S_REM_KEY,
    S_UP,
    S_UP_E,
    S_UP_K,
    S_DN,
    S_DN_LE,
    S_DN_LK,
    S_DN_RE,
    S_DN_RK,
    S_DN_CHK,
    S_SWAP1,
    S_SWAP2,
    S_HEAP_DONE,
    S_RB_RD,
    S_RB_CHK,
    S_RB_NEXT,
    S_FIN,
    S_FIN_E,
    S_FIN_K
  } fsm_e;

  typedef struct packed {
    logic [2:0]              req_type;
    logic [ID_W-1:0]         element_id;
    logic signed [KEY_W-1:0] key_value;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]         min_element;
    logic signed [KEY_W-1:0] min_key;
    logic [ID_W-1:0]         heap_size;
    logic                    heap_empty;
    logic [1:0]              status_code;
  } rsp_t;

endpackage

// ----- rtl/imh_ram.sv -----
// ----------------------------------------------------------------------------
// imh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/indexed_min_heap.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap
// One-based binary min-heap over element ids with signed Q16.16 keys.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid_i / req_stall_o / req_i): one item per request
//    (set key, update, insert, remove, read min, threshold rebuild).
//  - Response channel (rsp_valid_o / rsp_stall_i / rsp_o): exactly one item
//    per request, in order, showing the heap top, count and status.
//  - A request is taken only when the sequencer is idle; req_stall_o is high
//    while an item is being worked on, so one item is in flight at a time.
//  - The next request can be taken in the cycle after the response item
//    is loaded into the output register.
//  - Update, insert and remove add a sift: a level moving up reads the
//    parent and its key, then compares and swaps; a level moving down reads
//    each child and its key before comparing and swapping. Insert and remove
//    first swap slots. A rebuild walks every valid id and inserts and sifts
//    up each id below threshold.
//  - Every step is one access per memory plus one shared signed key compare;
//    the memory read latency sets the per-level cost.
//  - Reset: a clearing pass over all NUM_ELEMENTS entries writes zero keys
//    and the identity maps; requests are stalled until it ends.
//  - A stalled response is held in the output register; the sequencer waits
//    at its final step until that register frees up.
// ----------------------------------------------------------------------------
module indexed_min_heap #(
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  imh_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output imh_pkg::rsp_t rsp_o
);

  localparam int IW = $clog2(NUM_ELEMENTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ELEMENTS - 1);

  // Sequencer and datapath registers
  imh_pkg::fsm_e state_q, state_d, ret_q, ret_d;
  logic [2:0]    op_q, op_d;
  logic signed [imh_pkg::KEY_W-1:0] kv_q, kv_d, key_q, key_d, nb_key_q, nb_key_d;
  logic [1:0]    status_q, status_d;
  logic [IW-1:0] cnt_q, cnt_d;        // heap count
  logic [IW-1:0] pos_q, pos_d;        // position of the moving element
  logic [IW-1:0] elem_q, elem_d;      // moving element
  logic [IW-1:0] nb_pos_q, nb_pos_d;  // swap partner: parent, best child or target slot
  logic [IW-1:0] nb_elem_q, nb_elem_d;
  logic [IW-1:0] cand_q, cand_d;      // child element being examined
  logic [IW-1:0] iter_q, iter_d;      // clear index / rebuild id
  logic [IW-1:0] top_q, top_d;
  logic          moved_q, moved_d;
  logic          rsp_valid_q, rsp_valid_d;
  imh_pkg::rsp_t rsp_q, rsp_d;

  // Memory ports
  logic                             k_we, p_we, e_we;
  logic [IW-1:0]                    k_waddr, k_raddr, p_waddr, p_raddr, e_waddr, e_raddr;
  logic [imh_pkg::KEY_W-1:0]        k_wdata, k_rdata;
  logic [IW-1:0]                    p_wdata, p_rdata, e_wdata, e_rdata;

  // Shared key comparator
  logic signed [imh_pkg::KEY_W-1:0] cmp_a, cmp_b;
  logic                             cmp_lt;

  logic          id_ok, in_heap, req_is_elem_op, rsp_load;
  logic [IW-1:0] up_pos, slot;
  logic [IW:0]   lc, rc, cnt_x;

  // key_store
  imh_ram #(.WIDTH(imh_pkg::KEY_W), .DEPTH(NUM_ELEMENTS)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (k_we),
    .waddr_i(k_waddr),
    .wdata_i(k_wdata),
    .raddr_i(k_raddr),
    .rdata_o(k_rdata)
  );

  // position_to_element
  imh_ram #(.WIDTH(IW), .DEPTH(NUM_ELEMENTS)) u_p2e_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  // element_to_position
  imh_ram #(.WIDTH(IW), .DEPTH(NUM_ELEMENTS)) u_e2p_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_waddr),
    .wdata_i(e_wdata),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  assign id_ok = (req_i.element_id != '0) &&
                 (32'(req_i.element_id) < 32'(NUM_ELEMENTS));
  assign req_is_elem_op = req_i.req_type inside {imh_pkg::OP_SET_KEY, imh_pkg::OP_UPDATE,
                                                 imh_pkg::OP_INSERT, imh_pkg::OP_REMOVE};
  assign in_heap = (e_rdata != '0) && (e_rdata <= cnt_q);
  assign up_pos  = pos_q >> 1;
  assign slot    = cnt_q + IW'(1);
  assign lc      = {pos_q, 1'b0};
  assign rc      = {pos_q, 1'b1};
  assign cnt_x   = {1'b0, cnt_q};
  assign cmp_lt  = cmp_a < cmp_b;
  assign rsp_load = !rsp_valid_q || !rsp_stall_i;

  // Comparator operand select
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_q)
      imh_pkg::S_UP_K: begin
        cmp_a = key_q;
        cmp_b = $signed(k_rdata);
      end
      imh_pkg::S_DN_LK: begin
        cmp_a = $signed(k_rdata);
        cmp_b = key_q;
      end
      imh_pkg::S_DN_RK: begin
        cmp_a = $signed(k_rdata);
        cmp_b = nb_key_q;
      end
      imh_pkg::S_RB_CHK: begin
        cmp_a = $signed(k_rdata);
        cmp_b = kv_q;
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      imh_pkg::S_CLEAR: if (iter_q == LAST_IDX) state_d = imh_pkg::S_IDLE;
      imh_pkg::S_IDLE: begin
        if (req_valid_i) begin
          if (req_is_elem_op) begin
            state_d = id_ok ? imh_pkg::S_LOOKUP : imh_pkg::S_FIN;
          end else if (req_i.req_type == imh_pkg::OP_REBUILD) begin
            state_d = imh_pkg::S_RB_RD;
          end else begin
            state_d = imh_pkg::S_FIN;
          end
        end
      end
      imh_pkg::S_LOOKUP: begin
        case (op_q)
          imh_pkg::OP_UPDATE: state_d = in_heap ? imh_pkg::S_UP : imh_pkg::S_FIN;
          imh_pkg::OP_INSERT: state_d = in_heap ? imh_pkg::S_FIN : imh_pkg::S_INS_RD;
          imh_pkg::OP_REMOVE: state_d = in_heap ? imh_pkg::S_REM_RD : imh_pkg::S_FIN;
          default:            state_d = imh_pkg::S_FIN;
        endcase
      end
      imh_pkg::S_INS_RD:   state_d = imh_pkg::S_INS_SWP;
      imh_pkg::S_INS_SWP:  state_d = imh_pkg::S_SWAP1;
      imh_pkg::S_INS_DONE: state_d = imh_pkg::S_UP;
      imh_pkg::S_REM_RD:   state_d = imh_pkg::S_REM_SWP;
      imh_pkg::S_REM_SWP:  state_d = imh_pkg::S_SWAP1;
      imh_pkg::S_REM_DONE: state_d = (pos_q < cnt_q) ? imh_pkg::S_REM_KEY : imh_pkg::S_FIN;
      imh_pkg::S_REM_KEY:  state_d = imh_pkg::S_UP;
      imh_pkg::S_UP: begin
        if (up_pos != '0)  state_d = imh_pkg::S_UP_E;
        else if (moved_q)  state_d = imh_pkg::S_HEAP_DONE;
        else               state_d = imh_pkg::S_DN;
      end
      imh_pkg::S_UP_E: state_d = imh_pkg::S_UP_K;
      imh_pkg::S_UP_K: begin
        if (cmp_lt)        state_d = imh_pkg::S_SWAP1;
        else if (moved_q)  state_d = imh_pkg::S_HEAP_DONE;
        else               state_d = imh_pkg::S_DN;
      end
      imh_pkg::S_DN:    state_d = (lc > cnt_x) ? imh_pkg::S_HEAP_DONE : imh_pkg::S_DN_LE;
      imh_pkg::S_DN_LE: state_d = imh_pkg::S_DN_LK;
      imh_pkg::S_DN_LK: state_d = (rc <= cnt_x) ? imh_pkg::S_DN_RE : imh_pkg::S_DN_CHK;
      imh_pkg::S_DN_RE: state_d = imh_pkg::S_DN_RK;
      imh_pkg::S_DN_RK: state_d = imh_pkg::S_DN_CHK;
      imh_pkg::S_DN_CHK: begin
        state_d = (nb_pos_q == pos_q) ? imh_pkg::S_HEAP_DONE : imh_pkg::S_SWAP1;
      end
      imh_pkg::S_SWAP1: state_d = imh_pkg::S_SWAP2;
      imh_pkg::S_SWAP2: state_d = ret_q;
      imh_pkg::S_HEAP_DONE: begin
        state_d = (op_q == imh_pkg::OP_REBUILD) ? imh_pkg::S_RB_NEXT : imh_pkg::S_FIN;
      end
      imh_pkg::S_RB_RD:  state_d = imh_pkg::S_RB_CHK;
      imh_pkg::S_RB_CHK: state_d = cmp_lt ? imh_pkg::S_INS_RD : imh_pkg::S_RB_NEXT;
      imh_pkg::S_RB_NEXT: begin
        state_d = (iter_q == LAST_IDX) ? imh_pkg::S_FIN : imh_pkg::S_RB_RD;
      end
      imh_pkg::S_FIN:   state_d = imh_pkg::S_FIN_E;
      imh_pkg::S_FIN_E: state_d = imh_pkg::S_FIN_K;
      imh_pkg::S_FIN_K: if (rsp_load) state_d = imh_pkg::S_IDLE;
      default: state_d = imh_pkg::S_IDLE;
    endcase
  end

  // Datapath register updates
  always_comb begin
    op_d        = op_q;
    kv_d        = kv_q;
    key_d       = key_q;
    nb_key_d    = nb_key_q;
    status_d    = status_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    elem_d      = elem_q;
    nb_pos_d    = nb_pos_q;
    nb_elem_d   = nb_elem_q;
    cand_d      = cand_q;
    iter_d      = iter_q;
    top_d       = top_q;
    moved_d     = moved_q;
    ret_d       = ret_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    case (state_q)
      imh_pkg::S_CLEAR: iter_d = iter_q + IW'(1);
      imh_pkg::S_IDLE: begin
        if (req_valid_i) begin
          op_d     = req_i.req_type;
          kv_d     = req_i.key_value;
          elem_d   = IW'(req_i.element_id);
          status_d = imh_pkg::STS_OK;
          if (req_is_elem_op && !id_ok) status_d = imh_pkg::STS_BAD_ID;
          if (req_i.req_type == imh_pkg::OP_REBUILD) begin
            cnt_d  = '0;
            iter_d = IW'(1);
          end
        end
      end
      imh_pkg::S_LOOKUP: begin
        pos_d   = e_rdata;
        moved_d = 1'b0;
        case (op_q)
          imh_pkg::OP_UPDATE: begin
            if (in_heap) key_d = kv_q;
            else         status_d = imh_pkg::STS_MEMBERSHIP;
          end
          imh_pkg::OP_INSERT: begin
            if (in_heap) status_d = imh_pkg::STS_MEMBERSHIP;
            else         key_d = $signed(k_rdata);
          end
          imh_pkg::OP_REMOVE: begin
            if (!in_heap) status_d = imh_pkg::STS_MEMBERSHIP;
          end
          default: begin
          end
        endcase
      end
      imh_pkg::S_INS_SWP: begin
        nb_pos_d  = slot;
        nb_elem_d = p_rdata;
        ret_d     = imh_pkg::S_INS_DONE;
      end
      imh_pkg::S_INS_DONE: begin
        cnt_d   = slot;
        moved_d = 1'b0;
      end
      imh_pkg::S_REM_SWP: begin
        // last element moves into the vacated position
        nb_pos_d  = pos_q;
        nb_elem_d = elem_q;
        pos_d     = cnt_q;
        elem_d    = p_rdata;
        ret_d     = imh_pkg::S_REM_DONE;
      end
      imh_pkg::S_REM_DONE: cnt_d = cnt_q - IW'(1);
      imh_pkg::S_REM_KEY: begin
        key_d   = $signed(k_rdata);
        moved_d = 1'b0;
      end
      imh_pkg::S_UP:   nb_pos_d  = up_pos;
      imh_pkg::S_UP_E: nb_elem_d = p_rdata;
      imh_pkg::S_UP_K: begin
        if (cmp_lt) begin
          moved_d = 1'b1;
          ret_d   = imh_pkg::S_UP;
        end
      end
      imh_pkg::S_DN: begin
        nb_pos_d = pos_q;
        nb_key_d = key_q;
      end
      imh_pkg::S_DN_LE: cand_d = p_rdata;
      imh_pkg::S_DN_LK: begin
        if (cmp_lt) begin
          nb_pos_d  = lc[IW-1:0];
          nb_elem_d = cand_q;
          nb_key_d  = $signed(k_rdata);
        end
      end
      imh_pkg::S_DN_RE: cand_d = p_rdata;
      imh_pkg::S_DN_RK: begin
        if (cmp_lt) begin
          nb_pos_d  = rc[IW-1:0];
          nb_elem_d = cand_q;
          nb_key_d  = $signed(k_rdata);
        end
      end
      imh_pkg::S_DN_CHK: ret_d = imh_pkg::S_DN;
      imh_pkg::S_SWAP2:  pos_d = nb_pos_q;
      imh_pkg::S_RB_CHK: begin
        if (cmp_lt) begin
          elem_d = iter_q;
          key_d  = $signed(k_rdata);
          pos_d  = e_rdata;
        end
      end
      imh_pkg::S_RB_NEXT: iter_d = iter_q + IW'(1);
      imh_pkg::S_FIN_E:   top_d  = p_rdata;
      imh_pkg::S_FIN_K: begin
        if (rsp_load) begin
          rsp_valid_d       = 1'b1;
          rsp_d.min_element = (cnt_q != '0) ? imh_pkg::ID_W'(top_q) : '0;
          rsp_d.min_key     = (cnt_q != '0) ? $signed(k_rdata) : '0;
          rsp_d.heap_size   = imh_pkg::ID_W'(cnt_q);
          rsp_d.heap_empty  = (cnt_q == '0);
          rsp_d.status_code = status_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Memory port control
  always_comb begin
    k_we = 1'b0; k_waddr = elem_q; k_wdata = kv_q; k_raddr = '0;
    p_we = 1'b0; p_waddr = pos_q;  p_wdata = nb_elem_q; p_raddr = '0;
    e_we = 1'b0; e_waddr = nb_elem_q; e_wdata = pos_q; e_raddr = '0;
    case (state_q)
      imh_pkg::S_CLEAR: begin
        k_we = 1'b1; k_waddr = iter_q; k_wdata = '0;
        p_we = 1'b1; p_waddr = iter_q; p_wdata = iter_q;
        e_we = 1'b1; e_waddr = iter_q; e_wdata = iter_q;
      end
      imh_pkg::S_IDLE: begin
        k_raddr = IW'(req_i.element_id);
        e_raddr = IW'(req_i.element_id);
      end
      imh_pkg::S_LOOKUP: begin
        k_we = (op_q == imh_pkg::OP_SET_KEY) || ((op_q == imh_pkg::OP_UPDATE) && in_heap);
      end
      imh_pkg::S_INS_RD:   p_raddr = slot;
      imh_pkg::S_REM_RD:   p_raddr = cnt_q;
      imh_pkg::S_REM_DONE: k_raddr = elem_q;
      imh_pkg::S_UP:       p_raddr = up_pos;
      imh_pkg::S_UP_E:     k_raddr = p_rdata;
      imh_pkg::S_DN:       p_raddr = lc[IW-1:0];
      imh_pkg::S_DN_LE:    k_raddr = p_rdata;
      imh_pkg::S_DN_LK:    p_raddr = rc[IW-1:0];
      imh_pkg::S_DN_RE:    k_raddr = p_rdata;
      imh_pkg::S_SWAP1: begin
        p_we = 1'b1; p_waddr = pos_q;     p_wdata = nb_elem_q;
        e_we = 1'b1; e_waddr = nb_elem_q; e_wdata = pos_q;
      end
      imh_pkg::S_SWAP2: begin
        p_we = 1'b1; p_waddr = nb_pos_q; p_wdata = elem_q;
        e_we = 1'b1; e_waddr = elem_q;   e_wdata = nb_pos_q;
      end
      imh_pkg::S_RB_RD: begin
        k_raddr = iter_q;
        e_raddr = iter_q;
      end
      imh_pkg::S_FIN:   p_raddr = IW'(1);
      imh_pkg::S_FIN_E: k_raddr = p_rdata;
      imh_pkg::S_FIN_K: k_raddr = top_q;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imh_pkg::S_CLEAR;
      ret_q       <= imh_pkg::S_UP;
      cnt_q       <= '0;
      iter_q      <= '0;
      moved_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      iter_q      <= iter_d;
      moved_q     <= moved_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    kv_q      <= kv_d;
    key_q     <= key_d;
    nb_key_q  <= nb_key_d;
    status_q  <= status_d;
    pos_q     <= pos_d;
    elem_q    <= elem_d;
    nb_pos_q  <= nb_pos_d;
    nb_elem_q <= nb_elem_d;
    cand_q    <= cand_d;
    top_q     <= top_d;
    rsp_q     <= rsp_d;
  end

  assign req_stall_o = (state_q != imh_pkg::S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
